// ----- hw/rtl/address_range_lookup_table_macros.svh -----
// Assertion macros for the address range lookup table.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef ADDRESS_RANGE_LOOKUP_TABLE_MACROS_SVH
`define ADDRESS_RANGE_LOOKUP_TABLE_MACROS_SVH

// Same-cycle implication.
`define ARLT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ARLT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/arlt_pkg.sv -----
// Shared types, constants and helpers of the address range lookup table.
// No dependencies.
package arlt_pkg;

  localparam int unsigned EntriesPerSpace = 64;
  localparam int unsigned TotalEntries    = 2 * EntriesPerSpace;
  localparam int unsigned SlotW           = $clog2(EntriesPerSpace);
  localparam int unsigned CntW            = SlotW + 1;
  localparam int unsigned EntryAddrW      = $clog2(TotalEntries);

  localparam logic CMD_TRACK      = 1'b0;
  localparam logic CMD_LOOKUP     = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  typedef struct packed {
    logic [63:0] size;
    logic [63:0] id;
    logic [63:0] base;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic        cmd;
    logic        space;
    logic [63:0] lookup_address;
    logic [63:0] capture_base;
    logic [63:0] replay_base;
    logic [63:0] buffer_id;
    logic [63:0] buffer_size;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] found_id;
    logic [63:0] found_base;
    logic [63:0] found_size;
    logic        status;
  } res_t;

  // Space 0 occupies the low half of the memory, space 1 the high half.
  function automatic logic [EntryAddrW-1:0] entry_addr(logic space, logic [SlotW-1:0] slot);
    entry_addr = EntryAddrW'(slot) + (space ? EntryAddrW'(EntriesPerSpace) : EntryAddrW'(0));
  endfunction

endpackage

// ----- hw/rtl/arlt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module arlt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/arlt_engine.sv -----
// Scan engine: walks a space's region-memory entries, one per cycle, then
// inserts/overwrites (track, per nonzero base) or checks the best (lookup).
// Depends on arlt_pkg and arlt_ram.
module arlt_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          ready_o,
  input  arlt_pkg::req_t req_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output arlt_pkg::res_t res_o
);

  typedef enum logic [2:0] {
    StIdle, StScan, StWrite, StCheck, StCmp, StDone
  } state_e;

  state_e state_q, state_d;
  arlt_pkg::req_t req_q, req_d;
  arlt_pkg::res_t res_q, res_d;

  logic [arlt_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                       rd_pend_q, rd_pend_d;
  logic [arlt_pkg::SlotW-1:0] rd_slot_q, rd_slot_d;
  logic                       phase_q, phase_d;
  logic                       match_q, match_d;
  logic [arlt_pkg::SlotW-1:0] match_slot_q, match_slot_d;
  logic                       free_q, free_d;
  logic [arlt_pkg::SlotW-1:0] free_slot_q, free_slot_d;
  logic                       found_q, found_d;
  logic                       dropped_q, dropped_d;
  logic [arlt_pkg::TotalEntries-1:0] valid_q, valid_d;

  // Best candidate of a lookup and the address offset into it.
  arlt_pkg::entry_t best_q, best_d;
  logic [63:0]      diff_q, diff_d;

  logic                            ram_we, ram_re;
  logic [arlt_pkg::EntryAddrW-1:0] ram_waddr, ram_raddr;
  logic [arlt_pkg::EntryW-1:0]     ram_wdata, ram_rdata;

  logic             cur_space;
  logic [63:0]      track_base;
  arlt_pkg::entry_t rd_entry;
  logic             rd_valid;
  logic             scan_end;
  logic             drop_now;

  arlt_ram #(
    .Width (arlt_pkg::EntryW),
    .Depth (arlt_pkg::TotalEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cur_space  = (req_q.cmd == arlt_pkg::CMD_LOOKUP) ? req_q.space : phase_q;
  assign track_base = phase_q ? req_q.replay_base : req_q.capture_base;
  assign rd_entry   = arlt_pkg::entry_t'(ram_rdata);
  assign rd_valid   = valid_q[arlt_pkg::entry_addr(cur_space, rd_slot_q)];
  assign scan_end   = (cnt_q == arlt_pkg::CntW'(arlt_pkg::EntriesPerSpace));
  assign drop_now   = !match_q && !free_q;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    res_d        = res_q;
    cnt_d        = cnt_q;
    rd_pend_d    = rd_pend_q;
    rd_slot_d    = rd_slot_q;
    phase_d      = phase_q;
    match_d      = match_q;
    match_slot_d = match_slot_q;
    free_d       = free_q;
    free_slot_d  = free_slot_q;
    found_d      = found_q;
    dropped_d    = dropped_q;
    valid_d      = valid_q;
    best_d       = best_q;
    diff_d       = diff_q;
    ram_re       = 1'b0;
    ram_raddr    = arlt_pkg::entry_addr(cur_space, cnt_q[arlt_pkg::SlotW-1:0]);
    ram_we       = 1'b0;
    ram_waddr    = arlt_pkg::entry_addr(phase_q, free_slot_q);
    ram_wdata    = {req_q.buffer_size, req_q.buffer_id, track_base};

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          req_d     = req_i;
          cnt_d     = '0;
          rd_pend_d = 1'b0;
          match_d   = 1'b0;
          free_d    = 1'b0;
          found_d   = 1'b0;
          dropped_d = 1'b0;
          phase_d   = 1'b0;
          res_d     = '0;
          if (req_i.cmd == arlt_pkg::CMD_LOOKUP) begin
            state_d = StScan;
          end else if (req_i.capture_base != '0) begin
            state_d = StScan;
          end else if (req_i.replay_base != '0) begin
            phase_d = 1'b1;
            state_d = StScan;
          end else begin
            state_d = StDone;
          end
        end
      end
      StScan: begin
        if (!scan_end) begin
          ram_re    = 1'b1;
          cnt_d     = cnt_q + 1'b1;
          rd_pend_d = 1'b1;
          rd_slot_d = cnt_q[arlt_pkg::SlotW-1:0];
        end else begin
          rd_pend_d = 1'b0;
        end
        if (rd_pend_q) begin
          if (req_q.cmd == arlt_pkg::CMD_LOOKUP) begin
            if (rd_valid && rd_entry.base <= req_q.lookup_address &&
                (!found_q || rd_entry.base > best_q.base)) begin
              found_d = 1'b1;
              best_d  = rd_entry;
            end
          end else begin
            if (rd_valid && rd_entry.base == track_base && !match_q) begin
              match_d      = 1'b1;
              match_slot_d = rd_slot_q;
            end
            if (!rd_valid && !free_q) begin
              free_d      = 1'b1;
              free_slot_d = rd_slot_q;
            end
          end
        end
        if (scan_end && !rd_pend_q) begin
          state_d = (req_q.cmd == arlt_pkg::CMD_LOOKUP) ? StCheck : StWrite;
        end
      end
      StWrite: begin
        // A matching base wins over a free slot; no write when neither exists.
        if (match_q) begin
          ram_we    = 1'b1;
          ram_waddr = arlt_pkg::entry_addr(phase_q, match_slot_q);
        end else if (free_q) begin
          ram_we    = 1'b1;
          valid_d[arlt_pkg::entry_addr(phase_q, free_slot_q)] = 1'b1;
        end
        dropped_d = dropped_q | drop_now;
        if (!phase_q && req_q.replay_base != '0) begin
          phase_d = 1'b1;
          cnt_d   = '0;
          match_d = 1'b0;
          free_d  = 1'b0;
          state_d = StScan;
        end else begin
          res_d        = '0;
          res_d.status = (dropped_q | drop_now) ? arlt_pkg::STATUS_DROPPED
                                                : arlt_pkg::STATUS_OK;
          state_d      = StDone;
        end
      end
      StCheck: begin
        diff_d  = req_q.lookup_address - best_q.base;
        state_d = StCmp;
      end
      StCmp: begin
        res_d = '0;
        if (found_q && diff_q < best_q.size) begin
          res_d.hit        = 1'b1;
          res_d.found_id   = best_q.id;
          res_d.found_base = best_q.base;
          res_d.found_size = best_q.size;
        end
        state_d = StDone;
      end
      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      res_q     <= '0;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      phase_q   <= 1'b0;
      match_q   <= 1'b0;
      free_q    <= 1'b0;
      found_q   <= 1'b0;
      dropped_q <= 1'b0;
      valid_q   <= '0;
    end else begin
      state_q   <= state_d;
      res_q     <= res_d;
      cnt_q     <= cnt_d;
      rd_pend_q <= rd_pend_d;
      phase_q   <= phase_d;
      match_q   <= match_d;
      free_q    <= free_d;
      found_q   <= found_d;
      dropped_q <= dropped_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    rd_slot_q    <= rd_slot_d;
    match_slot_q <= match_slot_d;
    free_slot_q  <= free_slot_d;
    best_q       <= best_d;
    diff_q       <= diff_d;
  end

  assign ready_o     = (state_q == StIdle);
  assign res_valid_o = (state_q == StDone);
  assign res_o       = res_q;

endmodule

// ----- hw/rtl/address_range_lookup_table.sv -----
// Address range lookup table: two region tables (capture and replay space).
//
// Input stream (s_axis): one beat is a track or a lookup command, selected by
// tuser[0]; tuser[1] picks the space for a lookup. Output stream (m_axis):
// exactly one result beat per input beat, in order.
// A lookup scans the named space's 64 entries in the region memory at one
// entry per cycle; its result is formed in StCheck and StCmp, then registered.
// A track scans each space whose base is not zero, capture space first;
// with both bases zero the engine goes straight to StDone and the result is
// then registered. The single read port of the region memory sets the scan pace.
// One item is worked on at a time; s_axis_tready is high whenever the engine
// is idle, even while a finished result waits in the output register.
// If the receiver stalls, the result is held in the output register and the
// next result waits in the engine until the register frees up.
// Reset clears all valid bits at once, so both tables are empty right after
// reset with no clearing pass.
// Depends on arlt_pkg, arlt_engine, arlt_ram and the assertion macro header.
`include "address_range_lookup_table_macros.svh"

module address_range_lookup_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // lookup_address, capture_base, replay_base, buffer_id, buffer_size
  input  logic [319:0] s_axis_tdata,
  // cmd, space
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // found_id, found_base, found_size
  output logic [191:0] m_axis_tdata,
  // hit, status
  output logic [1:0]   m_axis_tuser
);

  arlt_pkg::req_t req;
  arlt_pkg::res_t eng_res;
  logic           eng_ready;
  logic           eng_res_valid;
  logic           res_take;

  arlt_pkg::res_t out_q, out_d;
  logic           out_vld_q, out_vld_d;

  assign req.cmd            = s_axis_tuser[0];
  assign req.space          = s_axis_tuser[1];
  assign req.lookup_address = s_axis_tdata[63:0];
  assign req.capture_base   = s_axis_tdata[127:64];
  assign req.replay_base    = s_axis_tdata[191:128];
  assign req.buffer_id      = s_axis_tdata[255:192];
  assign req.buffer_size    = s_axis_tdata[319:256];

  arlt_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_axis_tvalid && eng_ready),
    .ready_o     (eng_ready),
    .req_i       (req),
    .res_valid_o (eng_res_valid),
    .res_ready_i (res_take),
    .res_o       (eng_res)
  );

  assign s_axis_tready = eng_ready;
  assign res_take      = !out_vld_q || m_axis_tready;

  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q;
    if (eng_res_valid && res_take) begin
      out_d     = eng_res;
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.found_size, out_q.found_base, out_q.found_id};
  assign m_axis_tuser  = {out_q.status, out_q.hit};

  `ARLT_ASSERT_NXT(a_busy_after_beat, s_axis_tvalid && s_axis_tready, !s_axis_tready, "engine took a beat but stayed idle")
  `ARLT_ASSERT_IMP(a_miss_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "miss result carries nonzero found fields")
  `ARLT_ASSERT_IMP(a_drop_no_hit, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0], "dropped track result flagged as hit")

endmodule

// ----- bench/tb_address_range_lookup_table.sv -----
// Testbench for address_range_lookup_table: directed and random track/lookup beats.
// A scoreboard keeps its own copy of both region tables and checks every result.
// Depends on arlt_pkg and the address_range_lookup_table RTL.
module tb_address_range_lookup_table;
  timeunit 1ns;
  timeprecision 1ps;

  import arlt_pkg::*;

  localparam logic SPACE_CAPTURE = 1'b0;
  localparam logic SPACE_REPLAY  = 1'b1;
  localparam int   POOL_DEPTH    = 80;
  localparam int   PHASE_ITEMS   = 283;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [319:0] s_axis_tdata  = '0;
  logic [1:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  address_range_lookup_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // shadow region tables
  bit          tbl_valid [2][EntriesPerSpace];
  logic [63:0] tbl_base  [2][EntriesPerSpace];
  logic [63:0] tbl_id    [2][EntriesPerSpace];
  logic [63:0] tbl_size  [2][EntriesPerSpace];

  logic [63:0] base_pool [2][POOL_DEPTH];

  req_t pending_beats [$];
  res_t awaited_results [$];
  req_t driven_beat;
  bit   beat_taken = 1'b0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   error_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   send_gap = 0;
  int   recv_gap = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Overwrites a matching base, else takes the lowest free slot; 0 when full.
  function automatic bit record_region(input logic sp, input logic [63:0] b,
                                       input logic [63:0] id, input logic [63:0] sz);
    int free_slot;
    free_slot = -1;
    for (int i = 0; i < EntriesPerSpace; i++) begin
      if (tbl_valid[sp][i] && tbl_base[sp][i] == b) begin
        tbl_id[sp][i]   = id;
        tbl_size[sp][i] = sz;
        return 1'b1;
      end
      if (!tbl_valid[sp][i] && free_slot < 0) free_slot = i;
    end
    if (free_slot < 0) return 1'b0;
    tbl_valid[sp][free_slot] = 1'b1;
    tbl_base[sp][free_slot]  = b;
    tbl_id[sp][free_slot]    = id;
    tbl_size[sp][free_slot]  = sz;
    return 1'b1;
  endfunction

  function automatic res_t apply_to_tables(input req_t rq);
    res_t r;
    bit   found;
    int   best;
    r = '0;
    r.status = STATUS_OK;
    if (rq.cmd == CMD_TRACK) begin
      if (rq.capture_base != 0) begin
        if (!record_region(SPACE_CAPTURE, rq.capture_base, rq.buffer_id, rq.buffer_size))
          r.status = STATUS_DROPPED;
      end
      if (rq.replay_base != 0) begin
        if (!record_region(SPACE_REPLAY, rq.replay_base, rq.buffer_id, rq.buffer_size))
          r.status = STATUS_DROPPED;
      end
    end else begin
      found = 1'b0;
      best  = 0;
      for (int i = 0; i < EntriesPerSpace; i++) begin
        if (tbl_valid[rq.space][i] && tbl_base[rq.space][i] <= rq.lookup_address &&
            (!found || tbl_base[rq.space][i] > tbl_base[rq.space][best])) begin
          found = 1'b1;
          best  = i;
        end
      end
      // address >= base here, so the 65-bit end check reduces to the offset
      if (found &&
          (rq.lookup_address - tbl_base[rq.space][best]) < tbl_size[rq.space][best]) begin
        r.hit        = 1'b1;
        r.found_id   = tbl_id[rq.space][best];
        r.found_base = tbl_base[rq.space][best];
        r.found_size = tbl_size[rq.space][best];
      end
    end
    return r;
  endfunction

  function automatic req_t beat(input logic cmd, input logic sp, input logic [63:0] addr,
                                input logic [63:0] cb, input logic [63:0] rb,
                                input logic [63:0] id, input logic [63:0] sz);
    req_t rq;
    rq.cmd            = cmd;
    rq.space          = sp;
    rq.lookup_address = addr;
    rq.capture_base   = cb;
    rq.replay_base    = rb;
    rq.buffer_id      = id;
    rq.buffer_size    = sz;
    return rq;
  endfunction

  function automatic logic [63:0] pick_size();
    case ($urandom_range(5))
      0:       return 64'd0;
      1:       return 64'($urandom_range(1, 16));
      2:       return 64'($urandom_range(1, 1 << 20));
      3:       return rand64();
      4:       return ALL_ONES;
      default: return 64'd1 << $urandom_range(63);
    endcase
  endfunction

  // Mostly reused bases so overwrites happen; reach widens the pool over time.
  function automatic logic [63:0] pick_base(input logic sp, input int reach);
    case ($urandom_range(19))
      0, 1, 2: return 64'd0;
      3:       return rand64();
      default: return base_pool[sp][$urandom_range(reach)];
    endcase
  endfunction

  function automatic req_t make_lookup();
    req_t        rq;
    int          live [$];
    int          k;
    logic [63:0] b;
    logic [63:0] sz;
    rq = beat(CMD_LOOKUP, 1'($urandom_range(1)), rand64(), rand64(), rand64(), rand64(),
              rand64());
    for (int i = 0; i < EntriesPerSpace; i++)
      if (tbl_valid[rq.space][i]) live.push_back(i);
    if (live.size() != 0 && $urandom_range(7) != 0) begin
      k  = live[$urandom_range(live.size() - 1)];
      b  = tbl_base[rq.space][k];
      sz = tbl_size[rq.space][k];
      case ($urandom_range(5))
        0:       rq.lookup_address = b;
        1:       rq.lookup_address = b + sz - 64'd1;
        2:       rq.lookup_address = b + sz;
        3:       rq.lookup_address = (sz == 0) ? b : b + (rand64() % sz);
        4:       rq.lookup_address = b - 64'd1;
        default: rq.lookup_address = b + 64'($urandom_range(255));
      endcase
    end
    return rq;
  endfunction

  task automatic queue_item(input req_t rq);
    pending_beats.push_back(rq);
    n_sent++;
  endtask

  task automatic wait_for_results();
    while (n_checked < n_sent) @(posedge clk_i);
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    error_count++;
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // driver: new beat only once the previous one was taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_gap != 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(99) < recv_stall_pct) begin
        m_axis_tready <= 1'b0;
        if ($urandom_range(255) == 0) recv_gap = $urandom_range(1, 150);
      end else begin
        m_axis_tready <= 1'b1;
      end

      if (!s_axis_tvalid || beat_taken) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          driven_beat = pending_beats.pop_front();
          s_axis_tdata  <= {driven_beat.buffer_size, driven_beat.buffer_id,
                            driven_beat.replay_base, driven_beat.capture_base,
                            driven_beat.lookup_address};
          s_axis_tuser  <= {driven_beat.space, driven_beat.cmd};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
          if (send_idle_pct != 0 && $urandom_range(31) == 0) send_gap = $urandom_range(1, 160);
        end
      end
      beat_taken = 1'b0;
    end
  end

  // monitor: check results, then predict for the beat taken at this edge
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_checked++;
        if (awaited_results.size() == 0) begin
          flag_mismatch("unexpected result beat", m_axis_tdata[63:0], 64'd0);
        end else begin
          want = awaited_results.pop_front();
          if (m_axis_tuser[0] !== want.hit)
            flag_mismatch("hit", 64'(m_axis_tuser[0]), 64'(want.hit));
          if (m_axis_tuser[1] !== want.status)
            flag_mismatch("status", 64'(m_axis_tuser[1]), 64'(want.status));
          if (m_axis_tdata[63:0] !== want.found_id)
            flag_mismatch("found_id", m_axis_tdata[63:0], want.found_id);
          if (m_axis_tdata[127:64] !== want.found_base)
            flag_mismatch("found_base", m_axis_tdata[127:64], want.found_base);
          if (m_axis_tdata[191:128] !== want.found_size)
            flag_mismatch("found_size", m_axis_tdata[191:128], want.found_size);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(apply_to_tables(driven_beat));
        beat_taken = 1'b1;
      end
    end
  end

  initial begin
    int send_idle_by_phase [4];
    int recv_stall_by_phase [4];
    int n_random;
    int reach;
    send_idle_by_phase  = '{0, 64, 0, 31};
    recv_stall_by_phase = '{0, 0, 64, 31};
    n_random = 0;

    for (int sp = 0; sp < 2; sp++) begin
      for (int j = 0; j < POOL_DEPTH; j++) begin
        case ($urandom_range(3))
          0:       base_pool[sp][j] = rand64();
          1:       base_pool[sp][j] = 64'($urandom_range(1, 4096)) << 12;
          2:       base_pool[sp][j] = ALL_ONES - 64'($urandom_range(0, 1 << 20));
          default: base_pool[sp][j] = 64'($urandom_range(1, 65535)) << $urandom_range(16, 48);
        endcase
        if (base_pool[sp][j] == 0) base_pool[sp][j] = 64'd1;
      end
      base_pool[sp][0] = ALL_ONES;
      base_pool[sp][1] = 64'd1;
    end

    @(posedge rst_ni);

    // empty tables
    queue_item(beat(CMD_LOOKUP, SPACE_CAPTURE, 64'd0, 0, 0, 0, 0));
    queue_item(beat(CMD_LOOKUP, SPACE_REPLAY, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                    ALL_ONES));
    // both bases zero stores nothing
    queue_item(beat(CMD_TRACK, SPACE_REPLAY, ALL_ONES, 0, 0, ALL_ONES, ALL_ONES));
    queue_item(beat(CMD_TRACK, SPACE_CAPTURE, 0, 64'h1000, 0, 64'hA5A5_0000_0000_0001,
                    64'h100));
    queue_item(beat(CMD_LOOKUP, SPACE_CAPTURE, 64'h1000, 0, 0, 0, 0));
    queue_item(beat(CMD_LOOKUP, SPACE_CAPTURE, 64'h10FF, 0, 0, 0, 0));
    queue_item(beat(CMD_LOOKUP, SPACE_CAPTURE, 64'h1100, 0, 0, 0, 0));  // one past end
    queue_item(beat(CMD_LOOKUP, SPACE_CAPTURE, 64'h0FFF, 0, 0, 0, 0));  // below base
    queue_item(beat(CMD_LOOKUP, SPACE_REPLAY, 64'h1000, 0, 0, 0, 0));   // other space
    queue_item(beat(CMD_TRACK, SPACE_CAPTURE, 0, 0, ALL_ONES, ALL_ONES, ALL_ONES));
    queue_item(beat(CMD_LOOKUP, SPACE_REPLAY, ALL_ONES, 0, 0, 0, 0));
    // base + size past 2^64 must still hit
    queue_item(beat(CMD_TRACK, SPACE_REPLAY, 0, 64'hFFFF_FFFF_FFFF_F000, 64'd1, 64'd0,
                    ALL_ONES));
    queue_item(beat(CMD_LOOKUP, SPACE_CAPTURE, ALL_ONES, 0, 0, 0, 0));
    queue_item(beat(CMD_LOOKUP, SPACE_REPLAY, 64'd0, 0, 0, 0, 0));
    queue_item(beat(CMD_LOOKUP, SPACE_REPLAY, 64'h8000_0000_0000_0000, 0, 0, 0, 0));
    // overwrite with zero size
    queue_item(beat(CMD_TRACK, SPACE_CAPTURE, 0, 64'h1000, 64'h1000, 64'h5A5A_0000_0000_0002,
                    64'd0));
    queue_item(beat(CMD_LOOKUP, SPACE_CAPTURE, 64'h1000, 0, 0, 0, 0));
    queue_item(beat(CMD_TRACK, SPACE_CAPTURE, 0, 64'h2000, 64'h2000, 64'h3, 64'h10));
    // nearest lower region is empty, so miss
    queue_item(beat(CMD_LOOKUP, SPACE_CAPTURE, 64'h1800, 0, 0, 0, 0));
    queue_item(beat(CMD_LOOKUP, SPACE_CAPTURE, 64'h200F, 0, 0, 0, 0));
    queue_item(beat(CMD_LOOKUP, SPACE_REPLAY, 64'h2010, 0, 0, 0, 0));

    for (int ph = 0; ph < 4; ph++) begin
      wait_for_results();
      send_idle_pct  = send_idle_by_phase[ph];
      recv_stall_pct = recv_stall_by_phase[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        while (pending_beats.size() >= 2) @(posedge clk_i);
        if (ph == 3 && n % 60 == 59) wait_for_results();
        reach = 8 + n_random / 8;
        if (reach > POOL_DEPTH - 1) reach = POOL_DEPTH - 1;
        if ($urandom_range(99) < 45)
          queue_item(beat(CMD_TRACK, 1'($urandom_range(1)), rand64(),
                          pick_base(SPACE_CAPTURE, reach), pick_base(SPACE_REPLAY, reach),
                          rand64(), pick_size()));
        else
          queue_item(make_lookup());
        n_random++;
      end
    end

    wait_for_results();
    repeat (200) @(posedge clk_i);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/arlt_pkg.sv
hw/rtl/arlt_ram.sv
hw/rtl/arlt_engine.sv
hw/rtl/address_range_lookup_table.sv
bench/tb_address_range_lookup_table.sv
